// ----- design/edf_task_scheduler_assert.svh -----
// assertion macros shared by the scheduler modules
`ifndef EDF_TASK_SCHEDULER_ASSERT_SVH
`define EDF_TASK_SCHEDULER_ASSERT_SVH

// property that must hold on every clock outside reset
`define EDF_ASSERT_HOLD(lbl, ck, rn, expr, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (expr)) else $error(msg);

// same-cycle implication
`define EDF_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define EDF_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/edf_pkg.sv -----
// types, constants and helpers of the edf scheduler
package edf_pkg;

    localparam int MAX_TASKS     = 32;
    localparam int FRACTION_BITS = 16;

    localparam int IDX_W  = $clog2(MAX_TASKS);
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam int UTIL_W = FRACTION_BITS + 8;
    localparam int DIV_W  = 16 + FRACTION_BITS;
    localparam int DCNT_W = $clog2(DIV_W + 1);
    localparam int ID_W   = 6;

    localparam logic [UTIL_W-1:0] UTIL_ONE = UTIL_W'(1) << FRACTION_BITS;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    localparam logic [2:0] ST_CLEARED   = 3'd0;
    localparam logic [2:0] ST_LOADED    = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_RAN       = 3'd3;
    localparam logic [2:0] ST_IDLE_RES  = 3'd4;
    localparam logic [2:0] ST_NOT_SCHED = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_RUN,
        S_DEC
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // one-based task number, masked to the id width
    function automatic logic [ID_W-1:0] id_of(input logic [IDX_W-1:0] idx);
        logic [IDX_W:0] s;
        s = {1'b0, idx} + (IDX_W+1)'(1);
        return ID_W'(s);
    endfunction

endpackage

// ----- design/edf_task_scheduler.sv -----
// top level of the earliest-deadline-first task scheduler
//
// channel   direction  handshake                      payload
// command   in         start high while busy low      op, exec_time, deadline
// result    out        done high for one cycle        status, task_id, finished, tick_time
//
// clear, unused op, full table, zero-deadline load, unschedulable tick:
//   result in the cycle after the word is taken
// load: the bit-serial divider runs, then the sum is updated and the result registered
// tick: the deadline scan reads one entry a cycle; S_RUN, then S_DEC if a task is found, ends it
// asynchronous active-low reset clears control state; task memories hold no reset
// the result receiver cannot stall; busy stays high until the result strobe
`include "edf_task_scheduler_assert.svh"

module edf_task_scheduler
    import edf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       op,
    input  logic [15:0]      exec_time,
    input  logic [15:0]      deadline,
    output logic             busy,
    output logic             done,
    output logic [2:0]       status,
    output logic [ID_W-1:0]  task_id,
    output logic             finished,
    output logic [31:0]      tick_time
);

    // sequencer state
    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [UTIL_W-1:0]      sum_reg, sum_next;
    logic [31:0]            time_reg, time_next;
    logic                   bad_reg, bad_next;
    logic [MAX_TASKS-1:0]   tdone_reg, tdone_next;

    // scan bookkeeping
    logic [CNT_W-1:0]       scan_reg, scan_next;
    logic                   cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                   found_reg, found_next;
    logic [IDX_W-1:0]       best_reg, best_next;
    logic [15:0]            best_dl_reg, best_dl_next;
    logic [ID_W-1:0]        load_id_reg, load_id_next;

    // result registers
    logic                   done_reg, done_next;
    logic [2:0]             status_reg, status_next;
    logic [ID_W-1:0]        id_reg, id_next;
    logic                   fin_reg, fin_next;
    logic [31:0]            ttime_reg, ttime_next;

    // task memories
    logic [15:0]            rem_mem [MAX_TASKS];
    logic [15:0]            dl_mem  [MAX_TASKS];
    logic [15:0]            rd_rem_reg;
    logic [15:0]            rd_dl_reg;
    logic [IDX_W-1:0]       rd_addr;
    logic [IDX_W-1:0]       wr_addr;
    logic                   we_rem;
    logic                   we_dl;
    logic [15:0]            wr_rem;
    logic [15:0]            dec_rem;

    // divider hookup
    logic                   div_start;
    div_stat_t              div_stat;
    logic [DIV_W-1:0]       div_quo;
    logic [DIV_W:0]         sum_wide;

    logic                   accept;
    op_t                    op_in;

    assign accept  = start && !busy;
    assign op_in   = op_t'(op);
    assign dec_rem = rd_rem_reg - 16'd1;
    // utilization sum plus new term, one bit wider than the quotient; saturated at all ones in S_DIV
    assign sum_wide = (DIV_W+1)'(sum_reg) + {1'b0, div_quo};

    edf_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({exec_time, {FRACTION_BITS{1'b0}}}),
        .divisor  (deadline),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        time_next      = time_reg;
        bad_next       = bad_reg;
        tdone_next     = tdone_reg;
        scan_next      = scan_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        best_dl_next   = best_dl_reg;
        load_id_next   = load_id_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        id_next        = id_reg;
        fin_next       = fin_reg;
        ttime_next     = ttime_reg;
        div_start      = 1'b0;
        we_rem         = 1'b0;
        we_dl          = 1'b0;
        wr_addr        = count_reg[IDX_W-1:0];
        wr_rem         = exec_time;
        rd_addr        = scan_reg[IDX_W-1:0];

        // minimum-deadline compare on the word read last cycle
        if (cmp_valid_reg && !tdone_reg[cmp_idx_reg]
            && (!found_reg || (rd_dl_reg < best_dl_reg)))
        begin
            found_next   = 1'b1;
            best_next    = cmp_idx_reg;
            best_dl_next = rd_dl_reg;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    id_next  = '0;
                    fin_next = 1'b0;
                    case (op_in)
                        OP_CLEAR:
                        begin
                            count_next  = '0;
                            sum_next    = '0;
                            time_next   = '0;
                            bad_next    = 1'b0;
                            tdone_next  = '0;
                            done_next   = 1'b1;
                            status_next = ST_CLEARED;
                            ttime_next  = '0;
                        end
                        OP_LOAD:
                        begin
                            ttime_next = '0;
                            if (count_reg == CNT_W'(MAX_TASKS))
                            begin
                                done_next   = 1'b1;
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                we_rem = 1'b1;
                                we_dl  = 1'b1;
                                tdone_next[count_reg[IDX_W-1:0]] = (exec_time == 16'd0);
                                count_next   = count_reg + CNT_W'(1);
                                load_id_next = id_of(count_reg[IDX_W-1:0]);
                                if (deadline == 16'd0)
                                begin
                                    bad_next    = 1'b1;
                                    done_next   = 1'b1;
                                    status_next = ST_LOADED;
                                    id_next     = id_of(count_reg[IDX_W-1:0]);
                                end
                                else
                                begin
                                    div_start  = 1'b1;
                                    state_next = S_DIV;
                                end
                            end
                        end
                        OP_TICK:
                        begin
                            ttime_next = time_reg;
                            if (bad_reg || (sum_reg > UTIL_ONE))
                            begin
                                done_next   = 1'b1;
                                status_next = ST_NOT_SCHED;
                            end
                            else
                            begin
                                scan_next  = '0;
                                found_next = 1'b0;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = ST_IDLE_RES;
                            ttime_next  = time_reg;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    if (sum_wide[DIV_W:UTIL_W] != '0)
                    begin
                        sum_next = '1;
                    end
                    else
                    begin
                        sum_next = sum_wide[UTIL_W-1:0];
                    end
                    done_next   = 1'b1;
                    status_next = ST_LOADED;
                    id_next     = load_id_reg;
                    state_next  = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (scan_reg < count_reg)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_reg[IDX_W-1:0];
                    scan_next      = scan_reg + CNT_W'(1);
                end
                else if (!cmp_valid_reg)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                rd_addr = best_reg;
                if (found_reg)
                begin
                    state_next = S_DEC;
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = ST_IDLE_RES;
                    time_next   = time_reg + 32'd1;
                    state_next  = S_IDLE;
                end
            end
            S_DEC:
            begin
                we_rem    = 1'b1;
                wr_addr   = best_reg;
                wr_rem    = dec_rem;
                time_next = time_reg + 32'd1;
                if (dec_rem == 16'd0)
                begin
                    tdone_next[best_reg] = 1'b1;
                end
                done_next   = 1'b1;
                status_next = ST_RAN;
                id_next     = id_of(best_reg);
                fin_next    = (dec_rem == 16'd0);
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            sum_reg       <= '0;
            time_reg      <= '0;
            bad_reg       <= 1'b0;
            tdone_reg     <= '0;
            scan_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            time_reg      <= time_next;
            bad_reg       <= bad_next;
            tdone_reg     <= tdone_next;
            scan_reg      <= scan_next;
            cmp_valid_reg <= cmp_valid_next;
            found_reg     <= found_next;
            done_reg      <= done_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        best_reg    <= best_next;
        best_dl_reg <= best_dl_next;
        load_id_reg <= load_id_next;
        status_reg  <= status_next;
        id_reg      <= id_next;
        fin_reg     <= fin_next;
        ttime_reg   <= ttime_next;
    end

    // task memories, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we_rem)
        begin
            rem_mem[wr_addr] <= wr_rem;
        end
        if (we_dl)
        begin
            dl_mem[wr_addr] <= deadline;
        end
        rd_rem_reg <= rem_mem[rd_addr];
        rd_dl_reg  <= dl_mem[rd_addr];
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign status    = status_reg;
    assign task_id   = id_reg;
    assign finished  = fin_reg;
    assign tick_time = ttime_reg;

    `EDF_ASSERT_HOLD(a_count_range, clk, rst_n, count_reg <= CNT_W'(MAX_TASKS), "task count overflow")
    `EDF_ASSERT_IMPL(a_dec_has_task, clk, rst_n, state_reg == S_DEC, found_reg, "run without task")
    `EDF_ASSERT_IMPL(a_done_cause, clk, rst_n, done, $past(busy) || $past(start), "stray result")

endmodule

// ----- design/edf_divider.sv -----
// restoring divider, one quotient bit per cycle
`include "edf_task_scheduler_assert.svh"

module edf_divider
    import edf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [15:0]      divisor,
    output div_stat_t        stat,
    output logic [DIV_W-1:0] quotient
);

    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [15:0]       rem_reg, rem_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [15:0]       dvs_reg, dvs_next;
    logic [16:0]       shifted;
    logic [16:0]       trial;

    always_comb
    begin
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[DIV_W-1]};
        trial     = shifted - {1'b0, dvs_reg};
        if (start && (cnt_reg == '0))
        begin
            cnt_next = DCNT_W'(DIV_W);
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - DCNT_W'(1);
            if (!trial[16])
            begin
                rem_next = trial[15:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[15:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            done_next = (cnt_reg == DCNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

    `EDF_ASSERT_IMPL(a_done_not_busy, clk, rst_n, stat.done, !stat.busy, "divider done while busy")
    `EDF_ASSERT_IMPL(a_done_after_busy, clk, rst_n, stat.done, $past(stat.busy), "stray done")
    `EDF_ASSERT_NEXT(a_start_runs, clk, rst_n, start && !stat.busy, stat.busy, "start ignored")

endmodule

// ----- tb/sv/tb_edf_task_scheduler.sv -----
// self-checking testbench of the edf task scheduler: directed table, then random task sets
module tb_edf_task_scheduler;
    import edf_pkg::*;

    // watchdog, far above the slowest legal run (about 1700 words plus gaps)
    localparam int CYCLE_LIMIT = 1000000;
    // cycles left for a word still in flight at the end
    localparam int TAIL_CYCLES = 64;
    // random words per idling phase, unused ops not counted
    localparam int PHASE_WORDS = 550;
    localparam int DIR_ROWS    = 28;
    localparam logic [47:0] UTIL_MAX = (48'd1 << UTIL_W) - 48'd1;

    // one result word as it appears on the result ports
    typedef struct packed {
        logic [2:0]      status;
        logic [ID_W-1:0] task_id;
        logic            finished;
        logic [31:0]     tick_time;
    } sched_result_t;

    // one row of the directed table; typed rows carry their own expected word
    typedef struct packed {
        op_t           op;
        logic [15:0]   exec_time;
        logic [15:0]   deadline;
        logic          typed;
        sched_result_t exp;
    } dir_row_t;

    localparam sched_result_t UNTYPED = '0;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            start = 1'b0;
    logic [1:0]      op = OP_CLEAR;
    logic [15:0]     exec_time = '0;
    logic [15:0]     deadline = '0;
    logic            busy;
    logic            done;
    logic [2:0]      status;
    logic [ID_W-1:0] task_id;
    logic            finished;
    logic [31:0]     tick_time;

    // typed expectation travels with the command word it belongs to
    logic            cmd_typed = 1'b0;
    sched_result_t   cmd_exp = '0;

    // expected result words, oldest first
    sched_result_t   expected_results [$];

    int words_sent   = 0;
    int words_done   = 0;
    int useful_words = 0;
    int fail_count   = 0;
    int cycle_count  = 0;
    int idle_pct     = 0;

    // predictor copy of the scheduler tables
    logic [15:0]       tbl_remaining [MAX_TASKS];
    logic [15:0]       tbl_deadline  [MAX_TASKS];
    logic              tbl_done      [MAX_TASKS];
    int                tbl_count    = 0;
    logic [UTIL_W-1:0] util_acc     = '0;
    logic [31:0]       clock_now    = '0;
    logic              zero_dl_seen = 1'b0;

    // directed table: reset state, unused op, clear, zero exec, zero deadline,
    // saturating utilization, exactly 1.0 utilization and a deadline tie
    dir_row_t dir_rows [DIR_ROWS] = '{
        // fresh after reset: nothing loaded, tick is idle at time 0
        '{OP_TICK,  16'h0000, 16'h0000, 1'b1, '{ST_IDLE_RES,  6'd0, 1'b0, 32'd0}},
        // unused op only reports the current time
        '{OP_NONE,  16'hffff, 16'hffff, 1'b1, '{ST_IDLE_RES,  6'd0, 1'b0, 32'd1}},
        '{OP_CLEAR, 16'hffff, 16'hffff, 1'b1, '{ST_CLEARED,   6'd0, 1'b0, 32'd0}},
        '{OP_TICK,  16'h0000, 16'h0000, 1'b1, '{ST_IDLE_RES,  6'd0, 1'b0, 32'd0}},
        '{OP_LOAD,  16'd1,    16'hffff, 1'b1, '{ST_LOADED,    6'd1, 1'b0, 32'd0}},
        // zero execution time: stored already done
        '{OP_LOAD,  16'd0,    16'd7,    1'b1, '{ST_LOADED,    6'd2, 1'b0, 32'd0}},
        '{OP_LOAD,  16'd3,    16'd4,    1'b1, '{ST_LOADED,    6'd3, 1'b0, 32'd0}},
        '{OP_LOAD,  16'd1,    16'd8,    1'b1, '{ST_LOADED,    6'd4, 1'b0, 32'd0}},
        // run the set down to idle, predictor checked
        '{OP_TICK,  16'h0000, 16'h0000, 1'b0, UNTYPED},
        '{OP_TICK,  16'hffff, 16'hffff, 1'b0, UNTYPED},
        '{OP_TICK,  16'h0000, 16'h0000, 1'b0, UNTYPED},
        '{OP_TICK,  16'h0000, 16'h0000, 1'b0, UNTYPED},
        '{OP_TICK,  16'h0000, 16'h0000, 1'b0, UNTYPED},
        '{OP_TICK,  16'h0000, 16'h0000, 1'b0, UNTYPED},
        '{OP_TICK,  16'h0000, 16'h0000, 1'b0, UNTYPED},
        // huge term saturates the sum, set becomes unschedulable
        '{OP_LOAD,  16'hffff, 16'd1,    1'b1, '{ST_LOADED,    6'd5, 1'b0, 32'd0}},
        '{OP_TICK,  16'h0000, 16'h0000, 1'b1, '{ST_NOT_SCHED, 6'd0, 1'b0, 32'd8}},
        '{OP_CLEAR, 16'h0000, 16'h0000, 1'b1, '{ST_CLEARED,   6'd0, 1'b0, 32'd0}},
        // zero deadline poisons every tick until a clear
        '{OP_LOAD,  16'd5,    16'd0,    1'b1, '{ST_LOADED,    6'd1, 1'b0, 32'd0}},
        '{OP_TICK,  16'h0000, 16'h0000, 1'b1, '{ST_NOT_SCHED, 6'd0, 1'b0, 32'd0}},
        '{OP_CLEAR, 16'h0000, 16'h0000, 1'b1, '{ST_CLEARED,   6'd0, 1'b0, 32'd0}},
        // equal deadlines: lowest task number runs first
        '{OP_LOAD,  16'd1,    16'd4,    1'b1, '{ST_LOADED,    6'd1, 1'b0, 32'd0}},
        '{OP_LOAD,  16'd1,    16'd4,    1'b1, '{ST_LOADED,    6'd2, 1'b0, 32'd0}},
        '{OP_TICK,  16'h0000, 16'h0000, 1'b1, '{ST_RAN,       6'd1, 1'b1, 32'd0}},
        '{OP_TICK,  16'h0000, 16'h0000, 1'b1, '{ST_RAN,       6'd2, 1'b1, 32'd1}},
        '{OP_CLEAR, 16'h0000, 16'h0000, 1'b1, '{ST_CLEARED,   6'd0, 1'b0, 32'd0}},
        // utilization of exactly 1.0 is still schedulable
        '{OP_LOAD,  16'hffff, 16'hffff, 1'b1, '{ST_LOADED,    6'd1, 1'b0, 32'd0}},
        '{OP_TICK,  16'h0000, 16'h0000, 1'b1, '{ST_RAN,       6'd1, 1'b0, 32'd0}}
    };

    edf_task_scheduler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .op        (op),
        .exec_time (exec_time),
        .deadline  (deadline),
        .busy      (busy),
        .done      (done),
        .status    (status),
        .task_id   (task_id),
        .finished  (finished),
        .tick_time (tick_time)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // predictor: applies one accepted word to the table copy and returns its result word
    function automatic sched_result_t predict_schedule(input logic [1:0] p_op,
                                                       input logic [15:0] p_et,
                                                       input logic [15:0] p_dl);
        sched_result_t r;
        logic [47:0]   term;
        logic [47:0]   sum;
        int            best;
        bit            found;
        r     = '0;
        best  = 0;
        found = 1'b0;
        case (p_op)
            OP_CLEAR:
            begin
                for (int i = 0; i < MAX_TASKS; i++)
                begin
                    tbl_done[i] = 1'b0;
                end
                tbl_count    = 0;
                util_acc     = '0;
                clock_now    = '0;
                zero_dl_seen = 1'b0;
                r.status     = ST_CLEARED;
            end
            OP_LOAD:
            begin
                if (tbl_count >= MAX_TASKS)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    tbl_remaining[tbl_count] = p_et;
                    tbl_deadline[tbl_count]  = p_dl;
                    tbl_done[tbl_count]      = (p_et == 16'd0);
                    if (p_dl == 16'd0)
                    begin
                        zero_dl_seen = 1'b1;
                    end
                    else
                    begin
                        // fixed-point exec / deadline, sum saturates at all ones
                        term     = ({32'd0, p_et} << FRACTION_BITS) / {32'd0, p_dl};
                        sum      = {{(48-UTIL_W){1'b0}}, util_acc} + term;
                        util_acc = (sum > UTIL_MAX) ? UTIL_MAX[UTIL_W-1:0] : sum[UTIL_W-1:0];
                    end
                    tbl_count++;
                    r.status  = ST_LOADED;
                    r.task_id = ID_W'(tbl_count);
                end
            end
            OP_NONE:
            begin
                r.status    = ST_IDLE_RES;
                r.tick_time = clock_now;
            end
            default:
            begin
                r.tick_time = clock_now;
                if (zero_dl_seen || util_acc > UTIL_ONE)
                begin
                    // time stands still while the set is unschedulable
                    r.status = ST_NOT_SCHED;
                end
                else
                begin
                    // earliest deadline wins, strict compare keeps the lowest number on ties
                    for (int i = 0; i < tbl_count; i++)
                    begin
                        if (!tbl_done[i] && (!found || tbl_deadline[i] < tbl_deadline[best]))
                        begin
                            best  = i;
                            found = 1'b1;
                        end
                    end
                    clock_now = clock_now + 32'd1;
                    if (!found)
                    begin
                        r.status = ST_IDLE_RES;
                    end
                    else
                    begin
                        tbl_remaining[best] = tbl_remaining[best] - 16'd1;
                        if (tbl_remaining[best] == 16'd0)
                        begin
                            tbl_done[best] = 1'b1;
                            r.finished     = 1'b1;
                        end
                        r.status  = ST_RAN;
                        r.task_id = ID_W'(best + 1);
                    end
                end
            end
        endcase
        return r;
    endfunction

    // monitor: checks result words first, then records the word taken at this edge,
    // so a result and a new word on the same edge stay in order
    always @(posedge clk)
    begin : result_check
        sched_result_t exp;
        sched_result_t pred;
        if (rst_n)
        begin
            if (done)
            begin
                words_done++;
                if (expected_results.size() == 0)
                begin
                    if (fail_count < 10)
                    begin
                        $display("unexpected result word: status %0d task_id %0d finished %0d tick_time %0d",
                                 status, task_id, finished, tick_time);
                    end
                    fail_count++;
                end
                else
                begin
                    exp = expected_results.pop_front();
                    if (status !== exp.status || task_id !== exp.task_id ||
                        finished !== exp.finished || tick_time !== exp.tick_time)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("result mismatch: expected status %0d task_id %0d finished %0d tick_time %0d",
                                     exp.status, exp.task_id, exp.finished, exp.tick_time);
                            $display("                 actual   status %0d task_id %0d finished %0d tick_time %0d",
                                     status, task_id, finished, tick_time);
                        end
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                // the predictor always runs so its tables track the block
                pred = predict_schedule(op, exec_time, deadline);
                expected_results.push_back(cmd_typed ? cmd_exp : pred);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // drives one command word, holds it until taken, then idles at random
    task automatic send_word(input op_t w_op, input logic [15:0] w_et, input logic [15:0] w_dl,
                             input logic w_typed, input sched_result_t w_exp);
        start     <= 1'b1;
        op        <= w_op;
        exec_time <= w_et;
        deadline  <= w_dl;
        cmd_typed <= w_typed;
        cmd_exp   <= w_exp;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        words_sent++;
        if (w_op != OP_NONE)
        begin
            useful_words++;
        end
        // start stays high into the next word unless a gap is drawn
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // sender holds off until every word taken so far has its result
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (words_done != words_sent);
    endtask

    // one random sequence: mostly a clean task set run to completion,
    // sometimes raw noise on all fields
    task automatic run_sequence(input bit fill_table);
        int          kind;
        int          n_tasks;
        int          n_eff;
        int          et_sum;
        int          bad_idx;
        logic [15:0] et;
        logic [15:0] dl;
        kind = $urandom_range(99);
        if (!fill_table && kind < 20)
        begin
            // noise: any op, any field values, no clear in front
            n_tasks = $urandom_range(6, 1);
            repeat (n_tasks)
            begin
                send_word(op_t'($urandom_range(3)), 16'($urandom), 16'($urandom), 1'b0, UNTYPED);
            end
        end
        else
        begin
            send_word(OP_CLEAR, 16'($urandom), 16'($urandom), 1'b0, UNTYPED);
            // a full-table run now and then fills the table and may push loads past the last slot
            n_tasks = (fill_table || $urandom_range(9) == 0) ? $urandom_range(MAX_TASKS + 2, MAX_TASKS)
                                                             : $urandom_range(8, 1);
            n_eff   = (n_tasks > MAX_TASKS) ? MAX_TASKS : n_tasks;
            bad_idx = ($urandom_range(7) == 0) ? $urandom_range(n_tasks - 1) : -1;
            et_sum  = 0;
            for (int i = 0; i < n_tasks; i++)
            begin
                et = 16'($urandom_range(4));
                // deadline of at least et * n keeps the whole set at or below 1.0
                dl = (et == 16'd0) ? 16'($urandom_range(65535, 1))
                                   : 16'(int'(et) * n_eff * $urandom_range(4, 1));
                if (i == bad_idx)
                begin
                    dl = 16'd0;
                end
                if (i < MAX_TASKS)
                begin
                    et_sum += et;
                end
                send_word(OP_LOAD, et, dl, 1'b0, UNTYPED);
            end
            // enough ticks to finish every task, plus a few idle ones
            repeat (et_sum + $urandom_range(2))
            begin
                send_word(OP_TICK, 16'($urandom), 16'($urandom), 1'b0, UNTYPED);
            end
        end
    endtask

    initial
    begin : stimulus
        int target;
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            tbl_remaining[i] = '0;
            tbl_deadline[i]  = '0;
            tbl_done[i]      = 1'b0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 20;
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            send_word(dir_rows[i].op, dir_rows[i].exec_time, dir_rows[i].deadline,
                      dir_rows[i].typed, dir_rows[i].exp);
        end
        drain_results();

        // sender idling: light, heavy, none; each phase opens with a full table
        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 20 : (phase == 1) ? 64 : 0;
            target   = useful_words + PHASE_WORDS;
            run_sequence(1'b1);
            while (useful_words < target)
            begin
                run_sequence(1'b0);
            end
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            fail_count++;
        end
        if (fail_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/edf_pkg.sv
design/edf_divider.sv
design/edf_task_scheduler.sv
tb/sv/tb_edf_task_scheduler.sv
